// ----- rtl/cubic_bspline_curve_sampler_macros.svh -----
// Assertion macros used by the sampler controller.
`ifndef CUBIC_BSPLINE_CURVE_SAMPLER_MACROS_SVH
`define CUBIC_BSPLINE_CURVE_SAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cbs_pkg.sv -----
package cbs_pkg;

	localparam int unsigned PT_W   = 32;
	localparam int unsigned ACC_W  = 40;
	localparam int unsigned PROD_W = 58;
	localparam int unsigned T_W    = 17;
	localparam int unsigned N_W    = 5;
	localparam int unsigned DIV_W  = 48;
	localparam int unsigned CHUNK_W = 16;

	localparam logic [N_W-1:0] N_MAX   = 5'd30;
	localparam logic [N_W-1:0] N_RESET = 5'd30;

	// Bias that makes every Horner sum non-negative and is a multiple of six.
	localparam logic [ACC_W-1:0] DIV_BIAS   = 40'd824633720832;
	localparam logic [DIV_W:0]   DIV_OFFSET = 49'd137438953472;
	// ceil(2^21 / 6), exact for dividends below 6 * 2^16.
	localparam logic [18:0] RECIP6 = 19'd349526;

	typedef logic [T_W-1:0] t_tab_t [32];
	typedef logic [N_W-1:0] r_tab_t [32];

	localparam t_tab_t T_QUOT = '{
		17'd0, 17'(65536/1), 17'(65536/2), 17'(65536/3), 17'(65536/4),
		17'(65536/5), 17'(65536/6), 17'(65536/7), 17'(65536/8), 17'(65536/9),
		17'(65536/10), 17'(65536/11), 17'(65536/12), 17'(65536/13), 17'(65536/14),
		17'(65536/15), 17'(65536/16), 17'(65536/17), 17'(65536/18), 17'(65536/19),
		17'(65536/20), 17'(65536/21), 17'(65536/22), 17'(65536/23), 17'(65536/24),
		17'(65536/25), 17'(65536/26), 17'(65536/27), 17'(65536/28), 17'(65536/29),
		17'(65536/30), 17'd0
	};

	localparam r_tab_t T_REM = '{
		5'd0, 5'(65536%1), 5'(65536%2), 5'(65536%3), 5'(65536%4),
		5'(65536%5), 5'(65536%6), 5'(65536%7), 5'(65536%8), 5'(65536%9),
		5'(65536%10), 5'(65536%11), 5'(65536%12), 5'(65536%13), 5'(65536%14),
		5'(65536%15), 5'(65536%16), 5'(65536%17), 5'(65536%18), 5'(65536%19),
		5'(65536%20), 5'(65536%21), 5'(65536%22), 5'(65536%23), 5'(65536%24),
		5'(65536%25), 5'(65536%26), 5'(65536%27), 5'(65536%28), 5'(65536%29),
		5'(65536%30), 5'd0
	};

	typedef enum logic [1:0] {
		OUT_SAMPLE,
		OUT_LEAD,
		OUT_POINT
	} out_sel_t;

	typedef enum logic [1:0] {
		HS_A,
		HS_B,
		HS_C
	} hstep_t;

	typedef struct packed {
		logic           accept;
		logic           wr_win;
		logic [1:0]     wr_idx;
		logic           shift_win;
		logic           coef;
		logic           kind;
		logic           t_clear;
		logic           t_step;
		logic           mul;
		logic           add;
		hstep_t         hstep;
		logic           div_init;
		logic           div_step;
		logic           out_load;
		out_sel_t       out_sel;
		logic           out_last;
		logic [N_W-1:0] n;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

// ----- rtl/cbs_ctrl.sv -----
`include "cubic_bspline_curve_sampler_macros.svh"

module cbs_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic                    s_tlast,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [cbs_pkg::N_W-1:0] cfg_data,
	output cbs_pkg::dp_cmd_t        cmd,
	input  cbs_pkg::dp_stat_t       stat
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEAD,
		ST_COEF,
		ST_MUL,
		ST_ADD,
		ST_DIVI,
		ST_DIV,
		ST_PUT,
		ST_TAIL
	} state_t;

	state_t                  state_q;
	logic [1:0]              held_q;
	logic                    streaming_q;
	logic                    last_q;
	logic                    kind_q;
	logic [cbs_pkg::N_W-1:0] j_q;
	cbs_pkg::hstep_t         hstep_q;
	logic [1:0]              dstep_q;
	logic [cbs_pkg::N_W-1:0] n_cfg_q;
	logic [cbs_pkg::N_W-1:0] n_eff;
	logic                    accept;
	logic                    seg_end;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign seg_end   = (j_q == n_eff);

	always_comb begin
		if (n_cfg_q == '0) begin
			n_eff = cbs_pkg::N_W'(1);
		end else if (n_cfg_q > cbs_pkg::N_MAX) begin
			n_eff = cbs_pkg::N_MAX;
		end else begin
			n_eff = n_cfg_q;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.n         = n_eff;
		cmd.kind      = kind_q;
		cmd.hstep     = hstep_q;
		cmd.out_sel   = cbs_pkg::OUT_SAMPLE;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = accept;
				cmd.wr_win = accept && (held_q != 2'd3);
				cmd.wr_idx = held_q;
			end
			ST_LEAD: begin
				cmd.out_load = stat.out_free;
				cmd.out_sel  = cbs_pkg::OUT_LEAD;
			end
			ST_COEF: begin
				cmd.coef    = 1'b1;
				cmd.t_clear = 1'b1;
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_ADD:  cmd.add = 1'b1;
			ST_DIVI: cmd.div_init = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_PUT: begin
				cmd.out_load  = stat.out_free;
				cmd.out_last  = seg_end && !kind_q && !last_q;
				cmd.t_step    = stat.out_free;
				cmd.shift_win = stat.out_free && seg_end && !kind_q && !last_q;
			end
			ST_TAIL: begin
				cmd.out_load = stat.out_free;
				cmd.out_sel  = cbs_pkg::OUT_POINT;
				cmd.out_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			streaming_q <= 1'b0;
			last_q      <= 1'b0;
			kind_q      <= 1'b0;
			j_q         <= '0;
			hstep_q     <= cbs_pkg::HS_A;
			dstep_q     <= '0;
			n_cfg_q     <= cbs_pkg::N_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				n_cfg_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (held_q != 2'd3) begin
							held_q <= s_tlast ? 2'd0 : held_q + 2'd1;
							if (s_tlast) begin
								streaming_q <= 1'b0;
							end
						end else begin
							last_q  <= s_tlast;
							kind_q  <= 1'b0;
							state_q <= streaming_q ? ST_COEF : ST_LEAD;
						end
					end
				end
				ST_LEAD: begin
					if (stat.out_free) begin
						streaming_q <= 1'b1;
						state_q     <= ST_COEF;
					end
				end
				ST_COEF: begin
					j_q     <= '0;
					hstep_q <= cbs_pkg::HS_A;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					if (hstep_q == cbs_pkg::HS_C) begin
						state_q <= ST_DIVI;
					end else begin
						hstep_q <= cbs_pkg::hstep_t'(hstep_q + 2'd1);
						state_q <= ST_MUL;
					end
				end
				ST_DIVI: begin
					dstep_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dstep_q <= dstep_q + 2'd1;
					if (dstep_q == 2'd2) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (stat.out_free) begin
						if (seg_end) begin
							if (!kind_q && last_q) begin
								kind_q  <= 1'b1;
								state_q <= ST_COEF;
							end else if (!kind_q) begin
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_TAIL;
							end
						end else begin
							j_q     <= j_q + cbs_pkg::N_W'(1);
							hstep_q <= cbs_pkg::HS_A;
							state_q <= ST_MUL;
						end
					end
				end
				ST_TAIL: begin
					if (stat.out_free) begin
						held_q      <= '0;
						streaming_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CBS_ASSERT_NOW(a_load_when_free, cmd.out_load, stat.out_free, "output loaded while full")
	`CBS_ASSERT_NOW(a_j_in_range, state_q == ST_PUT, j_q <= n_eff, "sample index past segment")
	`CBS_ASSERT_NEXT(a_run_end_idle, cmd.out_load && cmd.out_last, state_q == ST_IDLE,
		"run ended without returning to idle")

endmodule

// ----- rtl/cbs_datapath.sv -----
module cbs_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  cbs_pkg::dp_cmd_t  cmd,
	output cbs_pkg::dp_stat_t stat,
	input  logic [63:0]       s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,
	output logic              m_tlast
);

	logic signed [cbs_pkg::PT_W-1:0]   win_q [2][3];
	logic signed [cbs_pkg::PT_W-1:0]   in_q [2];
	logic signed [cbs_pkg::PT_W-1:0]   pt [2][4];
	logic signed [cbs_pkg::PT_W-1:0]   din [2];
	logic signed [cbs_pkg::ACC_W-1:0]  p [2][4];
	logic signed [cbs_pkg::ACC_W-1:0]  a_q [2];
	logic signed [cbs_pkg::ACC_W-1:0]  b3_q [2];
	logic signed [cbs_pkg::ACC_W-1:0]  c3_q [2];
	logic signed [cbs_pkg::ACC_W-1:0]  d_q [2];
	logic signed [cbs_pkg::ACC_W-1:0]  acc_q [2];
	logic signed [cbs_pkg::ACC_W-1:0]  mop [2];
	logic signed [cbs_pkg::ACC_W-1:0]  addend [2];
	logic signed [cbs_pkg::PROD_W-1:0] prod_q [2];
	logic signed [cbs_pkg::T_W:0]      t_s;
	logic [cbs_pkg::T_W-1:0]           t_q;
	logic [cbs_pkg::N_W-1:0]           rem_q;
	logic [cbs_pkg::T_W-1:0]           t_nxt;
	logic [cbs_pkg::N_W:0]             rem_sum;
	logic [cbs_pkg::DIV_W-1:0]         dv_q [2];
	logic [cbs_pkg::DIV_W-1:0]         quot_q [2];
	logic [2:0]                        r_q [2];
	logic [18:0]                       dx [2];
	logic [37:0]                       dprod [2];
	logic [16:0]                       dq [2];
	logic [18:0]                       drem [2];
	logic [cbs_pkg::ACC_W-1:0]         biased [2];
	logic signed [cbs_pkg::DIV_W:0]    sv [2];
	logic [cbs_pkg::PT_W-1:0]          sat [2];
	logic                              m_tvalid_q;

	assign din[0] = s_tdata[31:0];
	assign din[1] = s_tdata[63:32];
	assign t_s    = $signed({1'b0, t_q});
	assign stat.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		for (int ax = 0; ax < 2; ax++) begin
			pt[ax][0] = cmd.kind ? win_q[ax][1] : win_q[ax][0];
			pt[ax][1] = cmd.kind ? win_q[ax][2] : win_q[ax][1];
			pt[ax][2] = cmd.kind ? in_q[ax] : win_q[ax][2];
			pt[ax][3] = in_q[ax];
			for (int k = 0; k < 4; k++) begin
				p[ax][k] = cbs_pkg::ACC_W'(pt[ax][k]);
			end
			mop[ax] = (cmd.hstep == cbs_pkg::HS_A) ? a_q[ax] : acc_q[ax];
			case (cmd.hstep)
				cbs_pkg::HS_A: addend[ax] = b3_q[ax];
				cbs_pkg::HS_B: addend[ax] = c3_q[ax];
				default:       addend[ax] = d_q[ax];
			endcase
			biased[ax] = $unsigned(acc_q[ax]) + cbs_pkg::DIV_BIAS;
			dx[ax]     = {r_q[ax], dv_q[ax][cbs_pkg::DIV_W-1 -: cbs_pkg::CHUNK_W]};
			dprod[ax]  = 38'(dx[ax]) * 38'(cbs_pkg::RECIP6);
			dq[ax]     = dprod[ax][37:21];
			drem[ax]   = dx[ax] - 19'(dq[ax]) * 19'd6;
			sv[ax]     = $signed({1'b0, quot_q[ax]}) - $signed(cbs_pkg::DIV_OFFSET);
			if (sv[ax] > $signed(49'sd2147483647)) begin
				sat[ax] = 32'h7FFF_FFFF;
			end else if (sv[ax] < -$signed(49'sd2147483648)) begin
				sat[ax] = 32'h8000_0000;
			end else begin
				sat[ax] = sv[ax][31:0];
			end
		end
	end

	always_comb begin
		t_nxt   = t_q + cbs_pkg::T_QUOT[cmd.n];
		rem_sum = {1'b0, rem_q} + {1'b0, cbs_pkg::T_REM[cmd.n]};
		if (rem_sum >= {1'b0, cmd.n}) begin
			t_nxt   = t_nxt + cbs_pkg::T_W'(1);
			rem_sum = rem_sum - {1'b0, cmd.n};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.t_clear) begin
			t_q   <= '0;
			rem_q <= '0;
		end else if (cmd.t_step) begin
			t_q   <= t_nxt;
			rem_q <= rem_sum[cbs_pkg::N_W-1:0];
		end
		for (int ax = 0; ax < 2; ax++) begin
			if (cmd.accept) begin
				in_q[ax] <= din[ax];
			end
			if (cmd.wr_win) begin
				win_q[ax][cmd.wr_idx] <= din[ax];
			end else if (cmd.shift_win) begin
				win_q[ax][0] <= win_q[ax][1];
				win_q[ax][1] <= win_q[ax][2];
				win_q[ax][2] <= in_q[ax];
			end
			if (cmd.coef) begin
				a_q[ax]  <= -p[ax][0] + 3 * (p[ax][1] - p[ax][2]) + p[ax][3];
				b3_q[ax] <= 3 * (p[ax][0] - 2 * p[ax][1] + p[ax][2]);
				c3_q[ax] <= 3 * (p[ax][2] - p[ax][0]);
				d_q[ax]  <= p[ax][0] + 4 * p[ax][1] + p[ax][2];
			end
			if (cmd.mul) begin
				prod_q[ax] <= mop[ax] * t_s;
			end
			if (cmd.add) begin
				acc_q[ax] <= $signed(prod_q[ax][cbs_pkg::ACC_W+15:16]) + addend[ax];
			end
			if (cmd.div_init) begin
				dv_q[ax]   <= cbs_pkg::DIV_W'(biased[ax]);
				quot_q[ax] <= '0;
				r_q[ax]    <= '0;
			end else if (cmd.div_step) begin
				dv_q[ax]   <= dv_q[ax] << cbs_pkg::CHUNK_W;
				quot_q[ax] <= {quot_q[ax][cbs_pkg::DIV_W-cbs_pkg::CHUNK_W-1:0], dq[ax][15:0]};
				r_q[ax]    <= drem[ax][2:0];
			end
		end
		if (cmd.out_load) begin
			m_tlast <= cmd.out_last;
			case (cmd.out_sel)
				cbs_pkg::OUT_LEAD:  m_tdata <= {win_q[1][0], win_q[0][0]};
				cbs_pkg::OUT_POINT: m_tdata <= {in_q[1], in_q[0]};
				default:            m_tdata <= {sat[1], sat[0]};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/cubic_bspline_curve_sampler.sv -----
// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         tdata: point_x[31:0], point_y[63:32]; tlast: last_point
// m_axis    out        tdata: out_x[31:0], out_y[63:32]; tlast: last_of_run
// cfg       in         data: samples_per_segment[4:0]
//
// Each curve sample passes through one shared multiplier per axis: three Horner
// multiply and add pairs, then a three-step divide by six and the output load.
// A point that starts or extends a curve is only stored; a segment point produces
// N + 1 samples, and the last point a second, closing segment as well.
// The point count resets to zero, and window entries are written before they are read.
// A stalled output word holds its sample and halts the sequencer until it is taken.
module cubic_bspline_curve_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // point_x, point_y
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // out_x, out_y
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	cbs_pkg::dp_cmd_t  cmd;
	cbs_pkg::dp_stat_t stat;

	cbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	cbs_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
